// ===== rtl/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 message digest core.
package sha1md_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned NUM_DIGEST_WORDS = 5;
   localparam logic [2:0] LAST_WORD_NUM = 3'd4;

   localparam word_type IV_WORDS [NUM_DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type K_ROUND_0 = 32'h5A827999;
   localparam word_type K_ROUND_1 = 32'h6ED9EBA1;
   localparam word_type K_ROUND_2 = 32'h8F1BBCDC;
   localparam word_type K_ROUND_3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARKER = 8'h80;

endpackage

// ===== rtl/sha1_message_digest_core.sv =====
// SHA-1 digest core: byte intake, padding sequencer and one shared round unit.
// A byte item is taken while the core is idle; every 64th byte starts 80 rounds, one per
// cycle through the single round adder, and then the chaining add. End of message adds
// the padding bytes, one or two compressions and 5 digest words, one per accepted result.
// No byte item is accepted while rounds, padding or digest output run. Synchronous
// active-high reset loads the initial hash values and clears state.
module sha1_message_digest_core
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_last_word
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD80 = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_ADD   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [6:0] LAST_ROUND = 7'd79;

   logic [2:0]   state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [511:0] sched_ff, sched_in;
   word_type     rw_ff [5];
   word_type     rw_in [5];
   word_type     chain_ff [5];
   word_type     chain_in [5];
   logic [6:0]   rnd_ff, rnd_in;
   logic [2:0]   oidx_ff, oidx_in;
   logic         pend_ff, pend_in;
   logic         pad_ff, pad_in;
   logic         two_ff, two_in;
   logic         final_ff, final_in;

   logic [7:0]   shift_byte;
   logic         do_shift;
   logic [5:0]   fill_next;
   logic         len_zone;
   logic [7:0]   len_byte;
   word_type     f_val, k_val, sum_val, w_new;

   assign fill_next = fill_ff + 6'd1;
   assign len_zone  = !two_ff && (fill_ff[5:3] == 3'b111);
   assign len_byte  = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];

   // Round function and constant by round range
   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = (rw_ff[1] & rw_ff[2]) | (~rw_ff[1] & rw_ff[3]);
         k_val = K_ROUND_0;
      end else if (rnd_ff < 7'd40) begin
         f_val = rw_ff[1] ^ rw_ff[2] ^ rw_ff[3];
         k_val = K_ROUND_1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (rw_ff[1] & rw_ff[2]) | (rw_ff[1] & rw_ff[3]) | (rw_ff[2] & rw_ff[3]);
         k_val = K_ROUND_2;
      end else begin
         f_val = rw_ff[1] ^ rw_ff[2] ^ rw_ff[3];
         k_val = K_ROUND_3;
      end
   end

   // Head of the schedule line is w[t]; taps give w[t+2], w[t+8], w[t+13]
   assign sum_val = {rw_ff[0][26:0], rw_ff[0][31:27]} + f_val + rw_ff[4]
                    + sched_ff[511:480] + k_val;

   always_comb begin
      word_type x;
      x = sched_ff[95:64] ^ sched_ff[255:224] ^ sched_ff[447:416] ^ sched_ff[511:480];
      w_new = {x[30:0], x[31]};
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      sched_in   = sched_ff;
      rw_in      = rw_ff;
      chain_in   = chain_ff;
      rnd_in     = rnd_ff;
      oidx_in    = oidx_ff;
      pend_in    = pend_ff;
      pad_in     = pad_ff;
      two_in     = two_ff;
      final_in   = final_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      do_shift   = 1'b0;
      shift_byte = 8'h00;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_byte_present) begin
                  do_shift   = 1'b1;
                  shift_byte = req_message_byte;
                  bits_in    = bits_ff + 64'd8;
                  pend_in    = req_end_of_message;
                  if (fill_next != 6'd0 && req_end_of_message) begin
                     state_in = ST_PAD80;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            do_shift   = 1'b1;
            shift_byte = PAD_MARKER;
            pad_in     = 1'b1;
            pend_in    = 1'b0;
            two_in     = (fill_ff[5:3] == 3'b111);
            state_in   = ST_PAD;
         end
         ST_PAD: begin
            do_shift   = 1'b1;
            shift_byte = len_zone ? len_byte : 8'h00;
            if (len_zone && fill_next == 6'd0) begin
               final_in = 1'b1;
            end
         end
         ST_ROUND: begin
            rw_in[4] = rw_ff[3];
            rw_in[3] = rw_ff[2];
            rw_in[2] = {rw_ff[1][1:0], rw_ff[1][31:2]};
            rw_in[1] = rw_ff[0];
            rw_in[0] = sum_val;
            sched_in = {sched_ff[479:0], w_new};
            rnd_in   = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < NUM_DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + rw_ff[i];
            end
            if (final_ff) begin
               state_in = ST_OUT;
               oidx_in  = 3'd0;
            end else if (pend_ff) begin
               state_in = ST_PAD80;
            end else if (pad_ff) begin
               two_in   = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == LAST_WORD_NUM) begin
                  chain_in = IV_WORDS;
                  bits_in  = 64'd0;
                  oidx_in  = 3'd0;
                  final_in = 1'b0;
                  pad_in   = 1'b0;
                  two_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Full buffer: launch the rounds from the chaining state
      if (do_shift) begin
         sched_in = {sched_ff[503:0], shift_byte};
         fill_in  = fill_next;
         if (fill_next == 6'd0) begin
            rw_in    = chain_ff;
            rnd_in   = 7'd0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= 6'd0;
         bits_ff  <= 64'd0;
         chain_ff <= IV_WORDS;
         rw_ff    <= '{default: 32'd0};
         rnd_ff   <= 7'd0;
         oidx_ff  <= 3'd0;
         pend_ff  <= 1'b0;
         pad_ff   <= 1'b0;
         two_ff   <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         chain_ff <= chain_in;
         rw_ff    <= rw_in;
         rnd_ff   <= rnd_in;
         oidx_ff  <= oidx_in;
         pend_ff  <= pend_in;
         pad_ff   <= pad_in;
         two_ff   <= two_in;
         final_ff <= final_in;
      end
      sched_ff <= sched_in;
   end

   assign rsp_digest_word = chain_ff[oidx_ff];
   assign rsp_word_number = oidx_ff;
   assign rsp_last_word   = (oidx_ff == LAST_WORD_NUM);

endmodule

// ===== rtl/sha1md_checker.sv =====
// Port-level checks for the SHA-1 digest core, bound to the digest core module.
module sha1md_checker
   import sha1md_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_number,
   input logic        rsp_last_word
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_number))
      else $error("stalled digest word changed");

   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while digest is emitted");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_number == LAST_WORD_NUM))
         && (rsp_word_number <= LAST_WORD_NUM))
      else $error("bad word number or last flag");

   // Advance through the five words without a gap
   a_word_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && (rsp_word_number == 3'($past(rsp_word_number) + 3'd1)))
      else $error("digest words out of sequence");

   a_first_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word_number == 3'd0)
      else $error("digest does not start at word zero");

endmodule

bind sha1_message_digest_core sha1md_checker u_checker (.*);

// ===== tb/sv/sha1_digest_checker.sv =====
// Digest checker: computes expected SHA-1 words for accepted items and checks each result.
module sha1_digest_checker
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_number,
   input  logic        rsp_last_word,
   output int          mismatch_count,
   output int          pending_words
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  number;
      logic        last;
   } digest_item_type;

   word_type        chain_q [NUM_DIGEST_WORDS];
   logic [7:0]      block_q [64];
   logic [5:0]      fill_q;
   logic [63:0]     bit_len_q;
   digest_item_type digest_q [$];

   function automatic void fold_block();
      word_type sched [80];
      word_type a, b, c, d, e, f, k, sum;
      for (int n = 0; n < 16; n++)
         sched[n] = {block_q[4*n], block_q[4*n+1], block_q[4*n+2], block_q[4*n+3]};
      for (int n = 16; n < 80; n++) begin
         sum = sched[n-3] ^ sched[n-8] ^ sched[n-14] ^ sched[n-16];
         sched[n] = {sum[30:0], sum[31]};
      end
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      e = chain_q[4];
      for (int n = 0; n < 80; n++) begin
         if (n < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND_0;
         end else if (n < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND_1;
         end else if (n < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND_2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND_3;
         end
         sum = {a[26:0], a[31:27]} + f + e + sched[n] + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      chain_q[0] = chain_q[0] + a;
      chain_q[1] = chain_q[1] + b;
      chain_q[2] = chain_q[2] + c;
      chain_q[3] = chain_q[3] + d;
      chain_q[4] = chain_q[4] + e;
   endfunction

   function automatic void restart_message();
      for (int n = 0; n < NUM_DIGEST_WORDS; n++)
         chain_q[n] = IV_WORDS[n];
      fill_q = '0;
      bit_len_q = '0;
   endfunction

   function automatic void absorb_item(logic [7:0] data, logic present, logic eom);
      int pos;
      digest_item_type item;
      if (present) begin
         block_q[fill_q] = data;
         fill_q = fill_q + 6'd1;
         bit_len_q = bit_len_q + 64'd8;
         if (fill_q == 0)
            fold_block();
      end
      if (eom) begin
         pos = fill_q;
         block_q[pos] = PAD_MARKER;
         pos++;
         // no room for the length: finish this block and pad a second one
         if (pos > 56) begin
            while (pos < 64) begin
               block_q[pos] = 8'h00;
               pos++;
            end
            fold_block();
            pos = 0;
         end
         while (pos < 56) begin
            block_q[pos] = 8'h00;
            pos++;
         end
         for (int n = 0; n < 8; n++)
            block_q[56+n] = bit_len_q[8*(7-n) +: 8];
         fold_block();
         for (int n = 0; n < NUM_DIGEST_WORDS; n++) begin
            item.word = chain_q[n];
            item.number = 3'(n);
            item.last = (3'(n) == LAST_WORD_NUM);
            digest_q.push_back(item);
         end
         restart_message();
      end
   endfunction

   always @(posedge clock) begin : track
      digest_item_type seen, want;
      if (reset) begin
         restart_message();
         digest_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.word = rsp_digest_word;
            seen.number = rsp_word_number;
            seen.last = rsp_last_word;
            if (digest_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected digest item: word %h number %0d last %b",
                           seen.word, seen.number, seen.last);
            end else begin
               want = digest_q.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                              want.word, want.number, want.last,
                              seen.word, seen.number, seen.last);
               end
            end
         end
         if (req_valid && req_ready)
            absorb_item(req_message_byte, req_byte_present, req_end_of_message);
      end
      pending_words = digest_q.size();
   end

endmodule

// ===== tb/sv/sha1_message_digest_core_tb.sv =====
// Testbench top: drives byte items and digest backpressure into the SHA-1 core.
module sha1_message_digest_core_tb;
   import sha1md_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int LONG_HOLD    = 600;
   localparam int RANDOM_ITEMS = 220;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_message_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_number;
   logic        rsp_last_word;

   int mismatch_count;
   int pending_words;
   int sent_items;
   int words_taken;
   bit fast_lane;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sha1_message_digest_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_message_byte   (req_message_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_number    (rsp_word_number),
      .rsp_last_word      (rsp_last_word)
   );

   sha1_digest_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_message_byte   (req_message_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_number    (rsp_word_number),
      .rsp_last_word      (rsp_last_word),
      .mismatch_count     (mismatch_count),
      .pending_words      (pending_words)
   );

   // Call at a rising edge; returns at the edge where the item is accepted.
   task automatic offer_item(input logic [7:0] data, input logic present, input logic eom);
      int gap;
      gap = fast_lane ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_message_byte <= data;
      req_byte_present <= present;
      req_end_of_message <= eom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (present || eom)
         sent_items++;
   endtask

   // Hold off the sender until every predicted digest word has come back.
   task automatic drain_digests();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      @(posedge clock);
   endtask

   task automatic send_message(input int length, input bit join_end);
      for (int n = 0; n < length; n++) begin
         if ($urandom_range(0, 7) == 0)
            offer_item(8'($urandom), 1'b0, 1'b0);
         offer_item(8'($urandom), 1'b1, join_end && (n == length - 1));
      end
      if (!join_end || length == 0)
         offer_item(8'($urandom), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel < 10)
         return $urandom_range(0, 12);
      else if (sel < 14) begin
         // lengths around the padding and block boundaries
         case ($urandom_range(0, 5))
            0: return 54;
            1: return 55;
            2: return 56;
            3: return 63;
            4: return 64;
            default: return 65;
         endcase
      end else if (sel == 14)
         return $urandom_range(0, 70);
      else
         return $urandom_range(100, 140);
   endfunction

   initial begin
      fast_lane = 1'b0;
      sent_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // nothing to do, then the empty message
      offer_item(8'h00, 1'b0, 1'b0);
      offer_item(8'hA5, 1'b0, 1'b1);
      // byte and end together
      offer_item(8'hFF, 1'b1, 1'b1);
      // end alone after some bytes
      offer_item(8'h00, 1'b1, 1'b0);
      offer_item(8'hFF, 1'b1, 1'b0);
      offer_item(8'h80, 1'b1, 1'b0);
      offer_item(8'h00, 1'b0, 1'b1);
      // "abc"
      offer_item(8'h61, 1'b1, 1'b0);
      offer_item(8'h62, 1'b1, 1'b0);
      offer_item(8'h63, 1'b1, 1'b1);
      offer_item(8'h5A, 1'b0, 1'b0);
      offer_item(8'h00, 1'b1, 1'b1);
      drain_digests();

      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         fast_lane = ($urandom_range(0, 3) == 0);
         send_message(pick_length(), $urandom_range(0, 1));
         if ($urandom_range(0, 5) == 0)
            drain_digests();
      end

      drain_digests();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_words == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Digest receiver with random stalls and one long hold-off.
   initial begin : digest_sink
      int gap;
      words_taken = 0;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         words_taken++;
         // hold off after the third digest while the sender keeps offering items
         if (words_taken == 15) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
